### rtl/ups_pkg.sv
// Shared constants, types and helper functions of the pixel replication upscaler.
package ups_pkg;

    localparam int MAX_SCALE  = 16;
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W   = 24;
    localparam int PAD_W   = 2;
    localparam int SCALE_W = 5;
    localparam int DIM_W   = 13;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int CNT_W   = $clog2(MAX_SCALE);
    localparam int IDX_W   = 2;

    localparam int IMG_END_BIT  = PIX_W + PAD_W;
    localparam int OUT_TDATA_W  = ((IMG_END_BIT + 1 + 7) / 8) * 8;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic [IDX_W-1:0] REG_SCALE  = 2'd0;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

    typedef struct packed {
        logic             from_ram;
        logic             refused;
        logic [PIX_W-1:0] pixel;
        logic [CNT_W-1:0] reps;
        logic [PAD_W-1:0] pad;
        logic             row_end;
        logic             image_end;
    } ups_issue_t;

    function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] v);
        logic [SCALE_W-1:0] r;
        if (v == '0)
            r = SCALE_W'(1);
        else if (v > SCALE_W'(MAX_SCALE))
            r = SCALE_W'(MAX_SCALE);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    // Padding to the next multiple of four bytes of width*scale*3.
    function automatic logic [PAD_W-1:0] pad_count(input logic [DIM_W-1:0] w,
                                                   input logic [SCALE_W-1:0] s);
        logic [3:0]       prod;
        logic [PAD_W-1:0] m;
        prod = {2'b00, w[1:0]} * {2'b00, s[1:0]};
        m    = prod[1:0] + {prod[0], 1'b0};
        return PAD_W'(~m + PAD_W'(1));
    endfunction

endpackage

### rtl/pixel_replication_upscaler.sv
// Top level of the pixel replication upscaler.
//  channel  direction  handshake            payload
//  s_       in         s_tvalid/s_tready    s_tdata = pixel, s_tuser = kind
//  m_       out        m_tvalid/m_tready    m_tdata = out_pixel,pad_bytes,image_end;
//                                           m_tlast = row_end, m_tuser = refused
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
// A source pixel holds the output register for scale copies, one per cycle unless stalled.
// A tick or a refused pixel yields a single transaction; a tick with no replay pending yields none.
// Replayed pixels come from the registered read of the row store, issued when the tick is accepted.
// Reset clears counters, sets scale, width, height to one; the row store needs no clearing pass.
// A stalled output holds its transaction; a new input is taken as the last copy leaves.
module pixel_replication_upscaler (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ups_pkg::PIX_W-1:0]       s_tdata,   // [23:0] pixel
    input  logic                            s_tuser,   // [0] kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ups_pkg::OUT_TDATA_W-1:0] m_tdata,   // [23:0] out_pixel, [25:24] pad_bytes,
                                                       // [26] image_end, [31:27] zero
    output logic                            m_tlast,
    output logic                            m_tuser,   // [0] refused
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ups_pkg::IDX_W-1:0]       cfg_index,
    input  logic [ups_pkg::DIM_W-1:0]       cfg_data
);
    import ups_pkg::*;

    logic             load_ok;
    logic             issue_valid;
    ups_issue_t       issue;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
    logic [PIX_W-1:0] wr_data;
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
    logic [PIX_W-1:0] rd_data;

    assign s_tready = load_ok;

    ups_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (s_tvalid),
        .in_kind     (s_tuser),
        .in_pixel    (s_tdata),
        .load_ok     (load_ok),
        .issue_valid (issue_valid),
        .issue       (issue),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr)
    );

    ups_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ups_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue_valid (issue_valid),
        .issue       (issue),
        .ram_data    (rd_data),
        .load_ok     (load_ok),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

### rtl/ups_ram.sv
// Generic simple dual-port RAM with registered read.
module ups_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/ups_ctrl.sv
// Configuration registers, raster counters, replay sequencing and row store access.
module ups_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [ups_pkg::IDX_W-1:0] cfg_index,
    input  logic [ups_pkg::DIM_W-1:0] cfg_data,
    input  logic                      in_valid,
    input  logic                      in_kind,
    input  logic [ups_pkg::PIX_W-1:0] in_pixel,
    input  logic                      load_ok,
    output logic                      issue_valid,
    output ups_pkg::ups_issue_t       issue,
    output logic                      wr_en,
    output logic [ups_pkg::COL_W-1:0] wr_addr,
    output logic [ups_pkg::PIX_W-1:0] wr_data,
    output logic                      rd_en,
    output logic [ups_pkg::COL_W-1:0] rd_addr
);
    import ups_pkg::*;

    logic [SCALE_W-1:0] scale_reg;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;

    logic [COL_W-1:0]   in_column_reg, in_column_next;
    logic [ROW_W-1:0]   in_row_reg, in_row_next;
    logic [CNT_W-1:0]   replays_left_reg, replays_left_next;
    logic [COL_W-1:0]   replay_column_reg, replay_column_next;
    logic [CNT_W-1:0]   replay_copy_reg, replay_copy_next;

    logic [SCALE_W-1:0] s_eff;
    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic [PAD_W-1:0]   pad;
    logic               accept;
    logic               col_last;
    logic               rep_col_last;
    logic               row_last;
    logic [SCALE_W-1:0] copy_inc;
    logic               finish;

    assign cfg_ready = 1'b1;
    assign s_eff     = eff_scale(scale_reg);
    assign w_eff     = eff_dim(width_reg, DIM_W'(MAX_WIDTH));
    assign h_eff     = eff_dim(height_reg, DIM_W'(MAX_HEIGHT));
    assign pad       = pad_count(w_eff, s_eff);
    assign accept    = in_valid && load_ok;

    assign col_last     = (DIM_W'(in_column_reg) + DIM_W'(1)) >= w_eff;
    assign rep_col_last = (DIM_W'(replay_column_reg) + DIM_W'(1)) >= w_eff;
    assign row_last     = (DIM_W'(in_row_reg) + DIM_W'(1)) >= h_eff;
    assign copy_inc     = SCALE_W'(replay_copy_reg) + SCALE_W'(1);

    assign wr_addr = in_column_reg;
    assign wr_data = in_pixel;
    assign rd_addr = replay_column_reg;

    always_comb
    begin
        in_column_next     = in_column_reg;
        in_row_next        = in_row_reg;
        replays_left_next  = replays_left_reg;
        replay_column_next = replay_column_reg;
        replay_copy_next   = replay_copy_reg;
        issue_valid        = 1'b0;
        issue              = '0;
        wr_en              = 1'b0;
        rd_en              = 1'b0;
        finish             = 1'b0;
        if (accept)
        begin
            if (in_kind == KIND_PIXEL)
            begin
                issue_valid = 1'b1;
                if (replays_left_reg != '0)
                begin
                    issue.refused = 1'b1;
                end
                else
                begin
                    wr_en       = 1'b1;
                    issue.pixel = in_pixel;
                    issue.reps  = CNT_W'(s_eff - SCALE_W'(1));
                    if (col_last)
                    begin
                        in_column_next = '0;
                        issue.row_end  = 1'b1;
                        issue.pad      = pad;
                        if (s_eff > SCALE_W'(1))
                        begin
                            replays_left_next  = CNT_W'(s_eff - SCALE_W'(1));
                            replay_column_next = '0;
                            replay_copy_next   = '0;
                        end
                        else
                        begin
                            finish = 1'b1;
                        end
                    end
                    else
                    begin
                        in_column_next = in_column_reg + COL_W'(1);
                    end
                end
            end
            else if (replays_left_reg != '0)
            begin
                issue_valid    = 1'b1;
                rd_en          = 1'b1;
                issue.from_ram = 1'b1;
                if (copy_inc >= s_eff)
                begin
                    replay_copy_next = '0;
                    if (rep_col_last)
                    begin
                        issue.row_end      = 1'b1;
                        issue.pad          = pad;
                        replay_column_next = '0;
                        replays_left_next  = replays_left_reg - CNT_W'(1);
                        if (replays_left_reg == CNT_W'(1))
                        begin
                            finish = 1'b1;
                        end
                    end
                    else
                    begin
                        replay_column_next = replay_column_reg + COL_W'(1);
                    end
                end
                else
                begin
                    replay_copy_next = copy_inc[CNT_W-1:0];
                end
            end
            if (finish)
            begin
                if (row_last)
                begin
                    in_row_next     = '0;
                    issue.image_end = 1'b1;
                end
                else
                begin
                    in_row_next = in_row_reg + ROW_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg         <= SCALE_W'(1);
            width_reg         <= DIM_W'(1);
            height_reg        <= DIM_W'(1);
            in_column_reg     <= '0;
            in_row_reg        <= '0;
            replays_left_reg  <= '0;
            replay_column_reg <= '0;
            replay_copy_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_SCALE:  scale_reg  <= cfg_data[SCALE_W-1:0];
                    REG_WIDTH:  width_reg  <= cfg_data;
                    REG_HEIGHT: height_reg <= cfg_data;
                    default:    ;
                endcase
            end
            in_column_reg     <= in_column_next;
            in_row_reg        <= in_row_next;
            replays_left_reg  <= replays_left_next;
            replay_column_reg <= replay_column_next;
            replay_copy_reg   <= replay_copy_next;
        end
    end

endmodule

### rtl/ups_out.sv
// Output register: holds one issued transaction and repeats source pixels scale times.
module ups_out (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            issue_valid,
    input  ups_pkg::ups_issue_t             issue,
    input  logic [ups_pkg::PIX_W-1:0]       ram_data,
    output logic                            load_ok,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ups_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast,
    output logic                            m_tuser
);
    import ups_pkg::*;

    logic             valid_reg, valid_next;
    ups_issue_t       desc_reg, desc_next;
    logic [CNT_W-1:0] reps_reg, reps_next;
    logic             last_rep;
    logic [PIX_W-1:0] pixel;
    logic [PAD_W-1:0] pad;
    logic             image_end;

    assign last_rep  = reps_reg == '0;
    assign load_ok   = !valid_reg || (m_tready && last_rep);
    assign pixel     = desc_reg.from_ram ? ram_data : desc_reg.pixel;
    assign pad       = last_rep ? desc_reg.pad : '0;
    assign image_end = last_rep && desc_reg.image_end;

    assign m_tvalid = valid_reg;
    assign m_tdata  = OUT_TDATA_W'({image_end, pad, pixel});
    assign m_tlast  = last_rep && desc_reg.row_end;
    assign m_tuser  = desc_reg.refused;

    always_comb
    begin
        valid_next = valid_reg;
        desc_next  = desc_reg;
        reps_next  = reps_reg;
        if (load_ok)
        begin
            valid_next = issue_valid;
            if (issue_valid)
            begin
                desc_next = issue;
                reps_next = issue.reps;
            end
        end
        else if (m_tready)
        begin
            reps_next = reps_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            reps_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            reps_reg  <= reps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
    end

endmodule

### rtl/ups_chk.sv
// Port-level checker for the pixel replication upscaler, bound to the top level.
module ups_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ups_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                            m_tlast,
    input logic                            m_tuser
);
    import ups_pkg::*;

    logic [PAD_W-1:0] pad_bytes;
    logic             image_end;

    assign pad_bytes = m_tdata[PIX_W +: PAD_W];
    assign image_end = m_tdata[IMG_END_BIT];

    a_refused_blank: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0 && !m_tlast)
        else $error("refused transaction carries data");

    a_image_end_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && image_end |-> m_tlast)
        else $error("image end without row end");

    a_pad_at_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && pad_bytes != '0 |-> m_tlast)
        else $error("padding away from row end");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("stalled output transaction changed");

endmodule

bind pixel_replication_upscaler ups_chk u_chk (.*);
